FILE: design/epd_pkg.sv
// Package for the escaped packet deframer: framing byte values, result kind
// codes and the result item type. No dependencies.
`default_nettype none

package epd_pkg;

   // framing bytes seen on the serial line
   localparam logic [7:0] BYTE_START = 8'hAA;
   localparam logic [7:0] BYTE_END   = 8'hCC;
   localparam logic [7:0] BYTE_ESC   = 8'hBB;

   // codes that follow an escape byte
   localparam logic [7:0] CODE_START = 8'h55;
   localparam logic [7:0] CODE_ESC   = 8'h44;
   localparam logic [7:0] CODE_END   = 8'h33;

   typedef logic [2:0] kind_type;

   // result kinds
   localparam kind_type KIND_DROP    = 3'd0;
   localparam kind_type KIND_START   = 3'd1;
   localparam kind_type KIND_DATA    = 3'd2;
   localparam kind_type KIND_END     = 3'd3;
   localparam kind_type KIND_RESTART = 3'd4;
   localparam kind_type KIND_ESCAPE  = 3'd5;
   localparam kind_type KIND_BADESC  = 3'd6;

   // one result item
   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
   } result_type;

endpackage

`default_nettype wire

FILE: design/epd_if.sv
// Valid/ready channel interfaces for the deframer: raw byte in, result out.
// Uses the kind type from epd_pkg.
`default_nettype none

interface epd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface epd_rsp_if;
   logic               valid;
   logic               ready;
   epd_pkg::kind_type  kind;
   logic [7:0]         out_byte;

   modport source (output valid, output kind, output out_byte, input ready);
   modport sink   (input valid, input kind, input out_byte, output ready);
endinterface

`default_nettype wire

FILE: design/escaped_packet_deframer.sv
// Top level of the escaped packet deframer: input register, framing decoder,
// result register. Uses epd_pkg, epd_req_if/epd_rsp_if and epd_decode.
//
// Each received byte gives exactly one result item (kind plus decoded byte).
// The block takes one byte per clock when the result side keeps up. An
// accepted byte passes through the input register and then the result
// register, fed by the one-level framing decoder, before it shows as a valid
// result. While a finished result waits, the empty input register can still
// take one byte. New bytes are refused only when both registers hold items and
// the result is not taken.
`default_nettype none

module escaped_packet_deframer (
   input  wire logic    clock,
   input  wire logic    reset,
   epd_req_if.sink      req_ch,
   epd_rsp_if.source    rsp_ch
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff;
   epd_pkg::result_type  out_result_ff;
   epd_pkg::result_type  dec_result;
   logic                 out_load;
   logic                 in_load;

   // pipeline advance
   assign out_load     = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || out_load;
   assign in_load      = req_ch.valid && req_ch.ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   epd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (out_load),
      .rx_byte (in_byte_ff),
      .result  (dec_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ch.ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_result_ff <= dec_result;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.kind     = out_result_ff.kind;
   assign rsp_ch.out_byte = out_result_ff.out_byte;

   // a held input item blocks new bytes only while the result side stalls
   a_in_block: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_load) |-> (!req_ch.ready && out_valid_ff && !rsp_ch.ready))
      else $error("input stalled without a result stall");

   // an accepted byte is always held in the input register in the next cycle
   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_load |=> in_valid_ff)
      else $error("accepted item lost from input register");

   // kinds without a byte carry zero
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_result_ff.kind == epd_pkg::KIND_DROP ||
                        out_result_ff.kind == epd_pkg::KIND_ESCAPE ||
                        out_result_ff.kind == epd_pkg::KIND_BADESC))
      |-> out_result_ff.out_byte == 8'h00)
      else $error("nonzero byte on a byteless result");

endmodule

`default_nettype wire

FILE: design/epd_decode.sv
// Framing decoder: holds the packet/escape flags and classifies one byte.
// The flags advance only when the caller moves the item on. Uses epd_pkg.
`default_nettype none

module epd_decode (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic [7:0]          rx_byte,
   output epd_pkg::result_type      result
);

   logic inside_packet_ff, inside_packet_in;
   logic escape_pending_ff, escape_pending_in;

   // classify the byte against the current framing state
   always_comb begin
      result.kind       = epd_pkg::KIND_DROP;
      result.out_byte   = 8'h00;
      inside_packet_in  = inside_packet_ff;
      escape_pending_in = escape_pending_ff;
      if (rx_byte == epd_pkg::BYTE_START) begin
         result.kind       = inside_packet_ff ? epd_pkg::KIND_RESTART : epd_pkg::KIND_START;
         result.out_byte   = epd_pkg::BYTE_START;
         inside_packet_in  = 1'b1;
         escape_pending_in = 1'b0;
      end else if (rx_byte == epd_pkg::BYTE_END && inside_packet_ff) begin
         // close also drops a pending escape
         result.kind       = epd_pkg::KIND_END;
         result.out_byte   = epd_pkg::BYTE_END;
         inside_packet_in  = 1'b0;
         escape_pending_in = 1'b0;
      end else if (inside_packet_ff && !escape_pending_ff) begin
         if (rx_byte == epd_pkg::BYTE_ESC) begin
            result.kind       = epd_pkg::KIND_ESCAPE;
            escape_pending_in = 1'b1;
         end else begin
            result.kind     = epd_pkg::KIND_DATA;
            result.out_byte = rx_byte;
         end
      end else if (inside_packet_ff) begin
         // byte after an escape
         escape_pending_in = 1'b0;
         case (rx_byte)
            epd_pkg::CODE_START: begin
               result.kind     = epd_pkg::KIND_DATA;
               result.out_byte = epd_pkg::BYTE_START;
            end
            epd_pkg::CODE_ESC: begin
               result.kind     = epd_pkg::KIND_DATA;
               result.out_byte = epd_pkg::BYTE_ESC;
            end
            epd_pkg::CODE_END: begin
               result.kind     = epd_pkg::KIND_DATA;
               result.out_byte = epd_pkg::BYTE_END;
            end
            default: begin
               result.kind = epd_pkg::KIND_BADESC;
            end
         endcase
      end
   end

   // framing state
   always_ff @(posedge clock) begin
      if (reset) begin
         inside_packet_ff  <= 1'b0;
         escape_pending_ff <= 1'b0;
      end else if (advance) begin
         inside_packet_ff  <= inside_packet_in;
         escape_pending_ff <= escape_pending_in;
      end
   end

   // an escape can only be pending inside a packet
   a_esc_in_packet: assert property (@(posedge clock) disable iff (reset)
      escape_pending_ff |-> inside_packet_ff)
      else $error("escape pending outside a packet");

   // an escape prefix leaves an escape pending
   a_esc_sets_pending: assert property (@(posedge clock) disable iff (reset)
      (advance && result.kind == epd_pkg::KIND_ESCAPE) |=> escape_pending_ff)
      else $error("escape prefix did not arm escape");

   // a packet end leaves the framer outside any packet
   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (advance && result.kind == epd_pkg::KIND_END) |=> !inside_packet_ff && !escape_pending_ff)
      else $error("packet end did not close the packet");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for escaped_packet_deframer: drives raw serial bytes,
// predicts the kind and decoded byte of every result and checks them in order.
// Depends on epd_pkg, epd_req_if/epd_rsp_if and the deframer RTL.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 650;
   localparam int MAX_REPORTS  = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   epd_req_if req_bus ();
   epd_rsp_if rsp_bus ();

   escaped_packet_deframer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [7:0]          byte_q [$];       // bytes waiting to be sent
   epd_pkg::result_type decoded_q [$];    // decoded results not yet seen
   int                  n_total;
   int                  n_sent = 0;
   int                  n_errors = 0;

   // predictor state
   bit         in_packet = 1'b0;
   bit         esc_pending = 1'b0;

   // decode one received byte and advance the framing state
   function automatic epd_pkg::result_type deframe_byte(logic [7:0] b);
      epd_pkg::result_type r;
      r.kind     = epd_pkg::KIND_DROP;
      r.out_byte = 8'h00;
      if (b == epd_pkg::BYTE_START) begin
         r.kind      = in_packet ? epd_pkg::KIND_RESTART : epd_pkg::KIND_START;
         r.out_byte  = epd_pkg::BYTE_START;
         in_packet   = 1'b1;
         esc_pending = 1'b0;
      end else if (b == epd_pkg::BYTE_END && in_packet) begin
         r.kind      = epd_pkg::KIND_END;
         r.out_byte  = epd_pkg::BYTE_END;
         in_packet   = 1'b0;
         esc_pending = 1'b0;
      end else if (in_packet && !esc_pending) begin
         if (b == epd_pkg::BYTE_ESC) begin
            r.kind      = epd_pkg::KIND_ESCAPE;
            esc_pending = 1'b1;
         end else begin
            r.kind     = epd_pkg::KIND_DATA;
            r.out_byte = b;
         end
      end else if (in_packet) begin
         // byte after an escape prefix
         case (b)
            epd_pkg::CODE_START: begin
               r.kind     = epd_pkg::KIND_DATA;
               r.out_byte = epd_pkg::BYTE_START;
            end
            epd_pkg::CODE_ESC: begin
               r.kind     = epd_pkg::KIND_DATA;
               r.out_byte = epd_pkg::BYTE_ESC;
            end
            epd_pkg::CODE_END: begin
               r.kind     = epd_pkg::KIND_DATA;
               r.out_byte = epd_pkg::BYTE_END;
            end
            default: r.kind = epd_pkg::KIND_BADESC;
         endcase
         esc_pending = 1'b0;
      end
      return r;
   endfunction

   // idle percentage by phase: sender light/receiver heavy, swapped, then none
   function automatic int idle_pct(bit receiver);
      int phase;
      phase = (n_total > 0) ? (n_sent * 3) / n_total : 0;
      case (phase)
         0:       return receiver ? 51 : 21;
         1:       return receiver ? 21 : 51;
         default: return 0;
      endcase
   endfunction

   function automatic void send_raw(logic [7:0] b);
      byte_q.push_back(b);
   endfunction

   // payload byte with framing bytes escaped
   function automatic void send_payload(logic [7:0] b);
      case (b)
         epd_pkg::BYTE_START: begin
            send_raw(epd_pkg::BYTE_ESC);
            send_raw(epd_pkg::CODE_START);
         end
         epd_pkg::BYTE_ESC: begin
            send_raw(epd_pkg::BYTE_ESC);
            send_raw(epd_pkg::CODE_ESC);
         end
         epd_pkg::BYTE_END: begin
            send_raw(epd_pkg::BYTE_ESC);
            send_raw(epd_pkg::CODE_END);
         end
         default: send_raw(b);
      endcase
   endfunction

   // driver: hold an item until it is taken, predict it on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         in_packet   = 1'b0;
         esc_pending = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decoded_q.push_back(deframe_byte(req_bus.rx_byte));
            n_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (byte_q.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
               req_bus.valid   <= 1'b1;
               req_bus.rx_byte <= byte_q.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each taken result against the oldest prediction
   always @(posedge clock) begin : result_check
      epd_pkg::result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (decoded_q.size() == 0) begin
               n_errors++;
               if (n_errors <= MAX_REPORTS)
                  $display("%t unexpected result: kind %0d byte %h", $realtime,
                           rsp_bus.kind, rsp_bus.out_byte);
            end else begin
               want = decoded_q.pop_front();
               if (rsp_bus.kind !== want.kind || rsp_bus.out_byte !== want.out_byte) begin
                  n_errors++;
                  if (n_errors <= MAX_REPORTS)
                     $display("%t result mismatch: kind %0d/%0d byte %h/%h (exp/got)",
                              $realtime, want.kind, rsp_bus.kind, want.out_byte,
                              rsp_bus.out_byte);
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= idle_pct(1'b1));
      end
   end

   // stimulus and end of run
   initial begin : run_control
      int         pick;
      int         len;
      logic [7:0] b;

      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;
      rsp_bus.ready   = 1'b0;

      // directed: noise outside a packet, then each framing corner
      send_raw(8'h00);
      send_raw(8'hFF);
      send_raw(epd_pkg::BYTE_END);      // end outside a packet is dropped
      send_raw(epd_pkg::BYTE_ESC);
      send_raw(epd_pkg::CODE_START);
      send_raw(epd_pkg::BYTE_START);
      send_raw(8'h00);
      send_raw(8'hFF);
      send_payload(epd_pkg::BYTE_START);
      send_payload(epd_pkg::BYTE_ESC);
      send_payload(epd_pkg::BYTE_END);
      send_raw(epd_pkg::BYTE_ESC);      // bad escape code
      send_raw(8'h12);
      send_raw(epd_pkg::BYTE_ESC);      // escape prefix after an escape
      send_raw(epd_pkg::BYTE_ESC);
      send_raw(epd_pkg::BYTE_ESC);      // start after an escape restarts
      send_raw(epd_pkg::BYTE_START);
      send_raw(epd_pkg::BYTE_START);    // start inside a packet
      send_raw(epd_pkg::BYTE_ESC);      // end after an escape closes
      send_raw(epd_pkg::BYTE_END);
      send_raw(epd_pkg::BYTE_START);
      send_raw(epd_pkg::BYTE_END);

      // random: mostly well-formed packets, some noise and broken framing
      while (byte_q.size() < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            repeat ($urandom_range(1, 4)) send_raw(8'($urandom_range(255)));
         end else begin
            send_raw(epd_pkg::BYTE_START);
            len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(4) == 0) begin
                  case ($urandom_range(5))
                     0:       b = epd_pkg::BYTE_START;
                     1:       b = epd_pkg::BYTE_ESC;
                     2:       b = epd_pkg::BYTE_END;
                     3:       b = epd_pkg::CODE_START;
                     4:       b = epd_pkg::CODE_ESC;
                     default: b = epd_pkg::CODE_END;
                  endcase
               end else begin
                  b = 8'($urandom_range(255));
               end
               send_payload(b);
               // occasional broken escape inside the payload
               if ($urandom_range(29) == 0) begin
                  send_raw(epd_pkg::BYTE_ESC);
                  send_raw(8'($urandom_range(255)));
               end
            end
            // some packets are left open so the next start is a restart
            if ($urandom_range(99) < 85) begin
               if ($urandom_range(19) == 0)
                  send_raw(epd_pkg::BYTE_ESC);
               send_raw(epd_pkg::BYTE_END);
            end
         end
      end
      n_total = byte_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (n_sent < n_total || decoded_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (n_errors == 0 && decoded_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // timeout
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
